FILE: src/bb_pkg.sv
// shared types, constants and helpers of the 3x3 box blur
// no dependencies
package bb_pkg;

    // default frame limits for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration register widths and reset values
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam logic [CFG_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // queue depths, output depth must cover the back pipeline stages
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int BACK_STAGES = 3;

    // result field widths
    localparam int PIX_BITS = 32;
    localparam int RGB_BITS = 24;
    localparam int OUTX_BITS = 10;
    localparam int OUTY_BITS = 12;
    localparam int SUM_BITS  = 12;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    // ceil(2^16 / 9), exact for sums below 2^15
    localparam logic [12:0] DIV9_RECIP   = 13'd7282;

    // per-item classification from the front end
    typedef struct packed {
        logic emit;
        logic last;
        logic skip_top;
        logic skip_bot;
        logic skip_left;
        logic skip_right;
    } t_flags;

    function automatic logic [7:0] div9(input logic [SUM_BITS-1:0] s);
        logic [24:0] p;
        p = 25'(s) * 25'(DIV9_RECIP);
        return p[23:16];
    endfunction

endpackage

FILE: src/bb_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/bb_fifo.sv
// small register fifo with fill count, depth a power of two
// no dependencies
module bb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push_ok, w_pop_ok;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: src/bb_front.sv
// front end: position counters, size clamping and item classification
// depends on bb_pkg
module bb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic [31:0]                           i_pixel_in,
    input  logic                                  i_drain,
    input  logic [bb_pkg::CFG_WIDTH_BITS-1:0]     i_frame_width,
    input  logic [bb_pkg::CFG_HEIGHT_BITS-1:0]    i_frame_height,
    input  logic                                  i_q_full,
    output logic                                  o_full,
    output logic                                  o_q_push,
    output logic [bb_pkg::RGB_BITS-1:0]           o_v,
    output logic [$clog2(MAX_WIDTH)-1:0]          o_col,
    output logic [$clog2(MAX_WIDTH)-1:0]          o_qx,
    output logic [$clog2(MAX_HEIGHT)-1:0]         o_qy,
    output bb_pkg::t_flags                        o_flags
);

    import bb_pkg::*;

    localparam int C_W  = $clog2(MAX_WIDTH);
    localparam int W_W  = $clog2(MAX_WIDTH + 1);
    localparam int H_W  = $clog2(MAX_HEIGHT + 1);
    localparam int R_W  = $clog2(MAX_HEIGHT + 2);
    localparam int QY_W = $clog2(MAX_HEIGHT);
    localparam int WC   = (W_W > CFG_WIDTH_BITS) ? W_W : CFG_WIDTH_BITS;
    localparam int HC   = (H_W > CFG_HEIGHT_BITS) ? H_W : CFG_HEIGHT_BITS;

    logic [C_W-1:0] r_col, n_col;
    logic [R_W-1:0] r_row, n_row;

    logic [WC-1:0]  w_wcfg;
    logic [HC-1:0]  w_hcfg;
    logic [W_W-1:0] w_w;
    logic [H_W-1:0] w_h;
    logic [R_W-1:0] w_hp1;
    logic           w_fix;
    logic [C_W-1:0] w_c;
    logic [R_W-1:0] w_r;
    logic [R_W-1:0] w_qy_full;
    logic [C_W-1:0] w_qx;
    logic [QY_W-1:0] w_qy;
    logic           w_accept;

    // clamp the frame size to the supported range
    always_comb begin
        w_wcfg = WC'(i_frame_width);
        w_hcfg = HC'(i_frame_height);
        if (w_wcfg < WC'(2)) begin
            w_w = W_W'(2);
        end else if (w_wcfg > WC'(MAX_WIDTH)) begin
            w_w = W_W'(MAX_WIDTH);
        end else begin
            w_w = W_W'(w_wcfg);
        end
        if (w_hcfg < HC'(2)) begin
            w_h = H_W'(2);
        end else if (w_hcfg > HC'(MAX_HEIGHT)) begin
            w_h = H_W'(MAX_HEIGHT);
        end else begin
            w_h = H_W'(w_hcfg);
        end
    end

    assign w_hp1 = R_W'(w_h) + 1'b1;

    // restart when the stored position lies outside the frame in use
    assign w_fix = (W_W'(r_col) >= w_w) || (r_row > w_hp1)
                   || ((r_row == w_hp1) && (r_col != '0));
    assign w_c   = w_fix ? '0 : r_col;
    assign w_r   = w_fix ? '0 : r_row;

    assign w_qx      = (w_c == '0) ? C_W'(w_w - 1'b1) : (w_c - 1'b1);
    assign w_qy_full = (w_c == '0) ? (w_r - R_W'(2)) : (w_r - 1'b1);
    assign w_qy      = QY_W'(w_qy_full);

    assign w_accept = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign o_q_push = w_accept;

    assign o_v   = (!i_drain && (w_r < R_W'(w_h))) ? i_pixel_in[31:8] : '0;
    assign o_col = w_c;
    assign o_qx  = w_qx;
    assign o_qy  = w_qy;

    always_comb begin
        o_flags.emit       = (w_r >= R_W'(2)) || ((w_r == R_W'(1)) && (w_c != '0));
        o_flags.last       = (W_W'(w_qx) == (w_w - 1'b1))
                             && (R_W'(w_qy) == (R_W'(w_h) - 1'b1));
        o_flags.skip_top   = (w_qy == '0);
        o_flags.skip_bot   = (R_W'(w_qy) + 1'b1) >= R_W'(w_h);
        o_flags.skip_left  = (w_qx == '0);
        o_flags.skip_right = (W_W'(w_qx) + 1'b1) >= w_w;
    end

    // raster advance, wrap after the single item of the flush row
    always_comb begin
        if (w_r == w_hp1) begin
            n_col = '0;
            n_row = '0;
        end else if ((W_W'(w_c) + 1'b1) < w_w) begin
            n_col = w_c + 1'b1;
            n_row = w_r;
        end else begin
            n_col = '0;
            n_row = w_r + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: src/bb_back.sv
// back end: line stores, 3x3 window, channel sums and divide by nine
// depends on bb_pkg and bb_ram
module bb_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_q_empty,
    output logic                                  o_q_pop,
    input  logic [bb_pkg::RGB_BITS-1:0]           i_v,
    input  logic [$clog2(MAX_WIDTH)-1:0]          i_col,
    input  logic [$clog2(MAX_WIDTH)-1:0]          i_qx,
    input  logic [$clog2(MAX_HEIGHT)-1:0]         i_qy,
    input  bb_pkg::t_flags                        i_flags,
    output logic                                  o_push,
    output logic [bb_pkg::PIX_BITS-1:0]           o_pixel_out,
    output logic [bb_pkg::OUTX_BITS-1:0]          o_out_x,
    output logic [bb_pkg::OUTY_BITS-1:0]          o_out_y,
    output logic                                  o_frame_last
);

    import bb_pkg::*;

    localparam int C_W  = $clog2(MAX_WIDTH);
    localparam int QY_W = $clog2(MAX_HEIGHT);

    // read stage
    logic                r_rd_vld;
    logic [RGB_BITS-1:0] r_rd_v;
    logic [C_W-1:0]      r_rd_col;
    logic [C_W-1:0]      r_rd_qx;
    logic [QY_W-1:0]     r_rd_qy;
    t_flags              r_rd_flags;
    logic                r_fwd;
    logic [RGB_BITS-1:0] r_fwd_a, r_fwd_b;

    // sum stage
    logic                 r_sum_vld;
    logic [SUM_BITS-1:0]  r_sum_r, r_sum_g, r_sum_b;
    logic [OUTX_BITS-1:0] r_sum_x;
    logic [OUTY_BITS-1:0] r_sum_y;
    logic                 r_sum_last;

    // quotient stage
    logic                 r_q_vld;
    logic [PIX_BITS-1:0]  r_q_pix;
    logic [OUTX_BITS-1:0] r_q_x;
    logic [OUTY_BITS-1:0] r_q_y;
    logic                 r_q_last;

    // window: two previous columns per row
    logic [RGB_BITS-1:0] r_w1 [3];
    logic [RGB_BITS-1:0] r_w2 [3];

    logic [RGB_BITS-1:0] w_ram_a, w_ram_b;
    logic [RGB_BITS-1:0] w_col [3];
    logic                w_pop;
    logic                w_step;
    logic                w_wr;
    logic [SUM_BITS-1:0] w_sr, w_sg, w_sb;

    assign w_pop   = i_en && !i_q_empty;
    assign o_q_pop = w_pop;
    assign w_step  = i_en && r_rd_vld;
    assign w_wr    = w_step;

    // row above above and row above, with bypass of a same-address write
    assign w_col[0] = r_fwd ? r_fwd_a : w_ram_a;
    assign w_col[1] = r_fwd ? r_fwd_b : w_ram_b;
    assign w_col[2] = r_rd_v;

    bb_ram #(
        .WIDTH (RGB_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr),
        .i_wr_addr (r_rd_col),
        .i_wr_data (w_col[1]),
        .i_rd_en   (w_pop),
        .i_rd_addr (i_col),
        .o_rd_data (w_ram_a)
    );

    bb_ram #(
        .WIDTH (RGB_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr),
        .i_wr_addr (r_rd_col),
        .i_wr_data (r_rd_v),
        .i_rd_en   (w_pop),
        .i_rd_addr (i_col),
        .o_rd_data (w_ram_b)
    );

    // masked 3x3 channel sums
    always_comb begin
        logic [RGB_BITS-1:0] px;
        logic                use_px;
        w_sr = '0;
        w_sg = '0;
        w_sb = '0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                px = (dc == 0) ? r_w1[dr] : ((dc == 1) ? r_w2[dr] : w_col[dr]);
                use_px = !((dr == 0) && r_rd_flags.skip_top)
                         && !((dr == 2) && r_rd_flags.skip_bot)
                         && !((dc == 0) && r_rd_flags.skip_left)
                         && !((dc == 2) && r_rd_flags.skip_right);
                if (use_px) begin
                    w_sr = w_sr + SUM_BITS'(px[23:16]);
                    w_sg = w_sg + SUM_BITS'(px[15:8]);
                    w_sb = w_sb + SUM_BITS'(px[7:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
            r_q_vld   <= 1'b0;
        end else if (i_en) begin
            r_rd_vld  <= w_pop;
            r_sum_vld <= r_rd_vld && r_rd_flags.emit;
            r_q_vld   <= r_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rd_v     <= i_v;
            r_rd_col   <= i_col;
            r_rd_qx    <= i_qx;
            r_rd_qy    <= i_qy;
            r_rd_flags <= i_flags;
            r_fwd      <= r_rd_vld && (i_col == r_rd_col);
            r_fwd_a    <= w_col[1];
            r_fwd_b    <= r_rd_v;
        end
        if (w_step) begin
            for (int i = 0; i < 3; i++) begin
                r_w1[i] <= r_w2[i];
                r_w2[i] <= w_col[i];
            end
            r_sum_r    <= w_sr;
            r_sum_g    <= w_sg;
            r_sum_b    <= w_sb;
            r_sum_x    <= OUTX_BITS'(r_rd_qx);
            r_sum_y    <= OUTY_BITS'(r_rd_qy);
            r_sum_last <= r_rd_flags.last;
        end
        if (i_en) begin
            r_q_pix  <= {div9(r_sum_r), div9(r_sum_g), div9(r_sum_b), ALPHA_OPAQUE};
            r_q_x    <= r_sum_x;
            r_q_y    <= r_sum_y;
            r_q_last <= r_sum_last;
        end
    end

    assign o_push       = i_en && r_q_vld;
    assign o_pixel_out  = r_q_pix;
    assign o_out_x      = r_q_x;
    assign o_out_y      = r_q_y;
    assign o_frame_last = r_q_last;

endmodule

FILE: src/box_blur_3x3_rgb_unit.sv
// top level of the 3x3 rgb box blur: config registers, queues, front and back
// depends on bb_pkg, bb_fifo, bb_front, bb_back (and bb_ram below it)
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  pixels in | push / full          | i_pixel_in, i_drain
//  blur out  | pop / empty          | o_pixel_out, o_out_x, o_out_y, o_frame_last
//  config    | psel, penable, pwrite| paddr, pwdata, prdata (pready tied high)
//
// one request per clock is taken while full is low and one result per clock is
// delivered while empty is low; the line stores take one write and one read per
// clock, which sets that rate; a result follows the request that completes its
// window (the request one row plus one pixel behind in raster order)
// synchronous active-low reset clears counters, queues and stage valids; the
// line stores need no clearing pass
// full rises when the four-entry mid queue fills; the back pipeline holds while
// the eight-entry output queue cannot absorb what is in flight
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH  = bb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          push,
    output logic                          full,
    input  logic [31:0]                   i_pixel_in,
    input  logic                          i_drain,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic [bb_pkg::PIX_BITS-1:0]   o_pixel_out,
    output logic [bb_pkg::OUTX_BITS-1:0]  o_out_x,
    output logic [bb_pkg::OUTY_BITS-1:0]  o_out_y,
    output logic                          o_frame_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import bb_pkg::*;

    localparam int C_W     = $clog2(MAX_WIDTH);
    localparam int QY_W    = $clog2(MAX_HEIGHT);
    localparam int FLG_W   = $bits(t_flags);
    localparam int MID_W   = RGB_BITS + C_W + C_W + QY_W + FLG_W;
    localparam int OUT_W   = PIX_BITS + OUTX_BITS + OUTY_BITS + 1;
    localparam int OUT_CW  = $clog2(OUT_DEPTH + 1);
    localparam int MID_CW  = $clog2(MID_DEPTH + 1);

    // configuration registers
    logic [CFG_WIDTH_BITS-1:0]  r_frame_width;
    logic [CFG_HEIGHT_BITS-1:0] r_frame_height;
    logic                       w_cfg_wr;

    // front to mid queue
    logic                w_f_push;
    logic [RGB_BITS-1:0] w_f_v;
    logic [C_W-1:0]      w_f_col, w_f_qx;
    logic [QY_W-1:0]     w_f_qy;
    t_flags              w_f_flags;
    logic                w_mid_full, w_mid_empty;
    logic [MID_W-1:0]    w_mid_din, w_mid_dout;
    logic [MID_CW-1:0]   w_mid_count;

    // mid queue to back
    logic                w_b_pop;
    logic [RGB_BITS-1:0] w_b_v;
    logic [C_W-1:0]      w_b_col, w_b_qx;
    logic [QY_W-1:0]     w_b_qy;
    t_flags              w_b_flags;
    logic                w_b_en;

    // back to output queue
    logic                 w_o_push;
    logic [PIX_BITS-1:0]  w_o_pix;
    logic [OUTX_BITS-1:0] w_o_x;
    logic [OUTY_BITS-1:0] w_o_y;
    logic                 w_o_last;
    logic [OUT_W-1:0]     w_out_din, w_out_dout;
    logic                 w_out_full;
    logic [OUT_CW-1:0]    w_out_count;

    // apb write in the access phase, byte address selects the register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_HEIGHT_BITS-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // front end classifies each request and queues it
    bb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_pixel_in     (i_pixel_in),
        .i_drain        (i_drain),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_full       (w_mid_full),
        .o_full         (full),
        .o_q_push       (w_f_push),
        .o_v            (w_f_v),
        .o_col          (w_f_col),
        .o_qx           (w_f_qx),
        .o_qy           (w_f_qy),
        .o_flags        (w_f_flags)
    );

    assign w_mid_din = {w_f_v, w_f_col, w_f_qx, w_f_qy, w_f_flags};

    bb_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_data  (w_mid_din),
        .o_full  (w_mid_full),
        .i_pop   (w_b_pop),
        .o_data  (w_mid_dout),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    assign {w_b_v, w_b_col, w_b_qx, w_b_qy, w_b_flags} = w_mid_dout;

    // back pipeline moves only while the output queue can take every
    // result still in its stages
    assign w_b_en = (w_out_count <= OUT_CW'(OUT_DEPTH - BACK_STAGES))
                    && !(w_mid_empty && (w_mid_count != '0));

    bb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_b_en),
        .i_q_empty    (w_mid_empty),
        .o_q_pop      (w_b_pop),
        .i_v          (w_b_v),
        .i_col        (w_b_col),
        .i_qx         (w_b_qx),
        .i_qy         (w_b_qy),
        .i_flags      (w_b_flags),
        .o_push       (w_o_push),
        .o_pixel_out  (w_o_pix),
        .o_out_x      (w_o_x),
        .o_out_y      (w_o_y),
        .o_frame_last (w_o_last)
    );

    assign w_out_din = {w_o_pix, w_o_x, w_o_y, w_o_last};

    // output queue, head is shown on the result ports
    bb_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_o_push && !w_out_full),
        .i_data  (w_out_din),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_dout),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign {o_pixel_out, o_out_x, o_out_y, o_frame_last} = w_out_dout;

endmodule
